// File: hw/rtl/priority_interrupt_controller_assert.svh
// Assertion macros used by the interrupt controller core (pic_core).
// No dependencies; include by bare file name inside a module body.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PIC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pic_pkg.sv
// Types, codes and helper functions for the priority interrupt controller.
// No dependencies.
package pic_pkg;

  typedef enum logic [2:0] {
    KIND_THRESHOLD = 3'd0,
    KIND_MASK      = 3'd1,
    KIND_RAISE     = 3'd2,
    KIND_ACK       = 3'd3,
    KIND_FM_ENABLE = 3'd4,
    KIND_FM_LINE   = 3'd5
  } pic_kind_t;

  localparam logic [2:0] FM_SOURCE  = 3'd4;
  localparam logic [7:0] MASK_RESET = 8'hf8;
  localparam logic [4:0] MASK_FORCE = 5'b11111;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] source_level;
    logic       fm_line;
  } pic_item_t;

  typedef struct packed {
    logic [7:0] pending;
    logic [3:0] vector;
    logic       request;
  } pic_result_t;

  // Highest set bit index, 0 when no bit is set.
  function automatic logic [2:0] pic_top_index(input logic [7:0] bits);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Request condition: something pending and its top index below the threshold.
  function automatic logic pic_below(input logic [7:0] bits, input logic [3:0] thr);
    logic [2:0] idx;
    idx = pic_top_index(bits);
    return (|bits) && ({1'b0, idx} < thr);
  endfunction

endpackage

// File: hw/rtl/pic_core.sv
// Controller state registers and the per-transfer update logic.
// Depends on pic_pkg and priority_interrupt_controller_assert.svh.
module pic_core
  import pic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  pic_item_t   item,
  output pic_result_t result
);

  logic [7:0] pending_r, pending_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [3:0] thr_r, thr_nxt;
  logic       fm_en_r, fm_en_nxt;
  logic       fm_lat_r, fm_lat_nxt;

  logic [2:0] raise_idx;
  logic [7:0] raised;
  logic [2:0] top_idx;
  logic       req;
  logic [3:0] vec;

  assign raise_idx = (item.kind == KIND_RAISE) ? item.source_level : FM_SOURCE;
  assign raised    = pending_r | (mask_r & (8'b1 << raise_idx));
  assign top_idx   = pic_top_index(pending_r);

  always_comb begin
    pending_nxt = pending_r;
    mask_nxt    = mask_r;
    thr_nxt     = thr_r;
    fm_en_nxt   = fm_en_r;
    fm_lat_nxt  = fm_lat_r;
    req         = 1'b0;
    vec         = 4'd0;
    case (item.kind)
      KIND_THRESHOLD: begin
        thr_nxt = item.data[3:0];
        req     = pic_below(pending_r, item.data[3:0]);
      end
      KIND_MASK: begin
        mask_nxt = {MASK_FORCE, item.data[0], item.data[1], item.data[2]};
      end
      KIND_RAISE: begin
        pending_nxt = raised;
        req         = pic_below(raised, thr_r);
      end
      KIND_ACK: begin
        // nothing pending clears bit 0, which is already clear
        pending_nxt = pending_r & ~(8'b1 << top_idx);
        vec         = {top_idx, 1'b0};
      end
      KIND_FM_ENABLE: begin
        fm_en_nxt = ~item.data[7];
        if (fm_lat_r && !item.data[7]) begin
          pending_nxt = raised;
          req         = pic_below(raised, thr_r);
        end
      end
      KIND_FM_LINE: begin
        fm_lat_nxt = item.fm_line;
        if (item.fm_line && fm_en_r) begin
          pending_nxt = raised;
          req         = pic_below(raised, thr_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'h00;
      mask_r    <= MASK_RESET;
      thr_r     <= 4'd0;
      fm_en_r   <= 1'b0;
      fm_lat_r  <= 1'b0;
    end else if (step) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
      thr_r     <= thr_nxt;
      fm_en_r   <= fm_en_nxt;
      fm_lat_r  <= fm_lat_nxt;
    end
  end

  assign result.pending = pending_nxt;
  assign result.vector  = vec;
  assign result.request = req;

`include "priority_interrupt_controller_assert.svh"

  `PIC_ASSERT_NOW(a_mask_forced, clk, rst_n, 1'b1, mask_r[7:3] == MASK_FORCE, "mask high bits not forced")
  `PIC_ASSERT_NOW(a_ack_no_req, clk, rst_n, step && item.kind == KIND_ACK, !result.request, "acknowledge raised a request")
  `PIC_ASSERT_NOW(a_vec_only_ack, clk, rst_n, step && item.kind != KIND_ACK, result.vector == 4'd0, "vector outside acknowledge")
  `PIC_ASSERT_NEXT(a_pend_sticky, clk, rst_n, step && item.kind != KIND_ACK, (pending_r & $past(pending_r)) == $past(pending_r), "pending bit lost without acknowledge")

endmodule

// File: hw/rtl/priority_interrupt_controller.sv
// Top level: input register, controller core and result register.
// Depends on pic_pkg and pic_core.
//
//  channel | direction | tdata (low bit up)                    | tuser
//  in_     | slave     | data[7:0] source_level[10:8] fm_line[11] | kind[2:0]
//  out_    | master    | request[0] vector[4:1] pending[12:5]  | -
//
// One item per cycle sustained while out_tready holds; an item passes the input
// register, then the state update into the result register, before out_tvalid
// rises for its result.
// The state registers and the result register advance together, so a stalled
// output holds both stages and in_tready drops once the input register is full.
// rst_n is synchronous, active low; it clears valid flags and controller state.
module priority_interrupt_controller
  import pic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data[7:0], source_level[10:8], fm_line[11], zeros
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // request[0], vector[4:1], pending[12:5], zeros
);

  pic_item_t   item_r;
  logic        item_valid_r;
  pic_result_t res;
  pic_result_t res_r;
  logic        out_valid_r;
  logic        advance;

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) item_valid_r <= in_tvalid;
      if (!out_valid_r || out_tready) out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind         <= in_tuser;
      item_r.data         <= in_tdata[7:0];
      item_r.source_level <= in_tdata[10:8];
      item_r.fm_line      <= in_tdata[11];
    end
    if (advance) res_r <= res;
  end

  pic_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .result (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.pending, res_r.vector, res_r.request};

endmodule
